[src/hrb_pkg.sv]
package hrb_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_EFFECT_ENABLE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_SCALE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_INTERVAL_MS = 2'd2;

   typedef struct packed {
      logic        effect_enable;
      logic [7:0]  led_scale;
      logic [15:0] min_interval_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      effect_enable:   1'b0,
      led_scale:       8'd255,
      min_interval_ms: 16'd30
   };

   // sizing
   localparam int SINE_TABLE_DEPTH_DEFAULT = 256;
   localparam int QUEUE_DEPTH              = 2;

   // timing constants
   localparam int HUE_PERIOD_MS    = 2000;
   localparam int BREATH_PERIOD_MS = 3000;

   // q1.15 brightness
   localparam logic [15:0] ONE_Q15          = 16'd32768;
   localparam logic [15:0] BRIGHT_BASE_Q15  = 16'd19661;
   localparam logic [15:0] BRIGHT_SWING_Q15 = 16'd13107;

   // pi/2 in q30 for the sine table
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // reciprocals, rounded up, exact over the operand ranges used
   localparam logic [29:0] RECIP_125    = 30'd549755814;   // 2^36 / 125
   localparam int          RECIP_125_SH = 36;
   localparam logic [30:0] RECIP_375    = 31'd1466015504;  // 2^39 / 375
   localparam int          RECIP_375_SH = 39;
   localparam logic [17:0] RECIP_FRAC   = 18'd134218;      // 2^24 / 125
   localparam int          RECIP_FRAC_SH = 24;
   localparam logic [28:0] RECIP_3000   = 29'd366503876;   // 2^40 / 3000
   localparam int          RECIP_3000_SH = 40;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_REM,
      BK_SECT,
      BK_MULT,
      BK_ADDR,
      BK_LOOK,
      BK_SINE,
      BK_SWING,
      BK_SHADE,
      BK_EMIT
   } bk_state_type;

endpackage

[src/hrb_if.sv]
interface hrb_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;

   modport source (output valid, output now_ms, input ready);
   modport sink (input valid, input now_ms, output ready);
endinterface

interface hrb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[src/hsv_rainbow_breathing_led.sv]
// Rainbow colour effect with a sine breathing brightness for the eye LEDs.
//
// req carries one millisecond timestamp per word (now_ms). A tick is taken
// when the effect is enabled and at least min_interval_ms have passed since
// the last tick that produced a colour (wrapping 32-bit difference); any
// other tick is consumed and produces nothing.
// rsp carries one colour word (red, green, blue) per tick that was taken.
// csr_write_en/csr_index/csr_wdata write effect_enable (0), led_scale (1)
// and min_interval_ms (2); other indexes are ignored.
//
// The back end's single shared arithmetic sequencer steps each tick through
// REM, SECT, MULT, ADDR, LOOK, SINE, SWING, SHADE and EMIT, and takes the
// next tick only once back in IDLE; the sine table read is registered.
// Ticks that are dropped never reach the back end.
// A two-word queue sits between the tick check and the sequencer, so req
// keeps accepting while a colour is being worked out.
// Reset: effect disabled, led_scale 255, min_interval_ms 30, last tick 0.
// When rsp stalls the colour is held, the sequencer waits on its final
// step, the queue fills and req.ready drops.
module hsv_rainbow_breathing_led #(
   parameter int SINE_TABLE_DEPTH = hrb_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   hrb_req_if.sink                          req,
   hrb_rsp_if.source                        rsp,
   input  logic                             csr_write_en,
   input  logic [hrb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hrb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hrb_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        push;
   logic [31:0] push_word;
   logic        queue_full;
   logic        queue_valid;
   logic        queue_pop;
   logic [31:0] queue_word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_EFFECT_ENABLE:   cfg_in.effect_enable   = csr_wdata[0];
            CSR_LED_SCALE:       cfg_in.led_scale       = csr_wdata[7:0];
            CSR_MIN_INTERVAL_MS: cfg_in.min_interval_ms = csr_wdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hrb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_word  (push_word)
   );

   hrb_word_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .pop       (queue_pop),
      .valid     (queue_valid),
      .head_word (queue_word)
   );

   hrb_back #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_valid (queue_valid),
      .queue_word  (queue_word),
      .queue_pop   (queue_pop),
      .rsp         (rsp)
   );

   a_scale_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write_en && (csr_index == CSR_LED_SCALE))
      |=> (cfg_ff.led_scale == $past(csr_wdata[7:0])))
      else $error("led_scale write lost");

endmodule

[src/hrb_sine_rom.sv]
module hrb_sine_rom #(
   parameter int DEPTH = hrb_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   output logic [15:0]              rdata
);
   import hrb_pkg::*;

   logic [15:0] sine_lut [DEPTH];
   logic [15:0] rdata_ff;

   // quarter-wave sine in q1.15 from a q30 taylor series up to x^13
   for (genvar k = 0; k < DEPTH; k++) begin : g_entry
      localparam logic [63:0] X  = (HALF_PI_Q30 * 64'(k)) / 64'(DEPTH);
      localparam logic [63:0] X2 = (X * X) >> 30;
      localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
      localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
      localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
      localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
      localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
      localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
      localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                               + longint'(T4) - longint'(T5) + longint'(T6);
      localparam logic [63:0] RND = (SUM < 0) ? 64'd0 : ((64'(SUM) + 64'd16384) >> 15);
      localparam logic [15:0] VAL = (RND > 64'(ONE_Q15)) ? ONE_Q15 : RND[15:0];
      assign sine_lut[k] = VAL;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= sine_lut[addr];
   end

   assign rdata = rdata_ff;

endmodule

[src/hrb_word_fifo.sv]
module hrb_word_fifo #(
   parameter int DEPTH = hrb_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [31:0] push_word,
   output logic        full,
   input  logic        pop,
   output logic        valid,
   output logic [31:0] head_word
);
   import hrb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [31:0]   entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign valid     = (count_ff != '0);
   assign head_word = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not fall on pop");

endmodule

[src/hrb_front.sv]
module hrb_front (
   input  logic             clock,
   input  logic             reset,
   hrb_req_if.sink          req,
   input  hrb_pkg::cfg_type cfg,
   input  logic             queue_full,
   output logic             push,
   output logic [31:0]      push_word
);
   import hrb_pkg::*;

   logic [31:0] last_ff, last_in;
   logic [31:0] gap;
   logic        take;

   assign req.ready = !queue_full;

   // wrapping distance since the last tick that produced a colour
   assign gap  = req.now_ms - last_ff;
   assign take = req.valid && req.ready && cfg.effect_enable
                 && (gap >= {16'd0, cfg.min_interval_ms});

   assign push      = take;
   assign push_word = req.now_ms;
   assign last_in   = take ? req.now_ms : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

endmodule

[src/hrb_back.sv]
module hrb_back #(
   parameter int SINE_TABLE_DEPTH = hrb_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  hrb_pkg::cfg_type cfg,
   input  logic             queue_valid,
   input  logic [31:0]      queue_word,
   output logic             queue_pop,
   hrb_rsp_if.source        rsp
);
   import hrb_pkg::*;

   localparam int KW  = $clog2(SINE_TABLE_DEPTH);
   localparam int IW  = $clog2(4 * SINE_TABLE_DEPTH);
   localparam int XW  = $clog2(BREATH_PERIOD_MS * 4 * SINE_TABLE_DEPTH);
   localparam int IPW = RECIP_3000_SH + IW;

   bk_state_type state_ff, state_in;
   logic         emit;
   logic         out_free;

   // datapath registers
   logic [31:0]   now_ff;
   logic [21:0]   hue_q_ff;
   logic [20:0]   breath_q_ff;
   logic [10:0]   hue_ms_ff;
   logic [11:0]   phase_ms_ff;
   logic [2:0]    sector_ff;
   logic [9:0]    rem_ff;
   logic [XW-1:0] xprod_ff;
   logic [9:0]    fraction_ff;
   logic [IW-1:0] idx_ff;
   logic [KW-1:0] addr_ff;
   logic [1:0]    quad_ff;
   logic          unity_ff;
   logic [28:0]   swing_prod_ff;
   logic [15:0]   br_ff;
   logic [15:0]   bt_ff;
   logic [15:0]   bq_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    red_ff, green_ff, blue_ff;

   // combinational terms
   logic [57:0]    hue_prod;
   logic [59:0]    breath_prod;
   logic [27:0]    hue_tmp;
   logic [28:0]    breath_tmp;
   logic [12:0]    hue3;
   logic [2:0]     sector_in;
   logic [12:0]    rem_full;
   logic [XW-1:0]  xprod_in;
   logic [34:0]    frac_prod;
   logic [IPW-1:0] idx_prod;
   logic [1:0]     quad_in;
   logic [IW-1:0]  quad_base;
   logic [IW-1:0]  offset_full;
   logic [KW-1:0]  offset;
   logic [KW-1:0]  addr_in;
   logic [15:0]    rom_data;
   logic [15:0]    mag;
   logic [13:0]    swing;
   logic [15:0]    br_in;
   logic [15:0]    r_sel, g_sel, b_sel;
   logic [23:0]    r_prod, g_prod, b_prod;

   hrb_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .clock (clock),
      .addr  (addr_ff),
      .rdata (rom_data)
   );

   assign out_free = !rsp_valid_ff || rsp.ready;

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (queue_valid) state_in = BK_REM;
         BK_REM:   state_in = BK_SECT;
         BK_SECT:  state_in = BK_MULT;
         BK_MULT:  state_in = BK_ADDR;
         BK_ADDR:  state_in = BK_LOOK;
         BK_LOOK:  state_in = BK_SINE;
         BK_SINE:  state_in = BK_SWING;
         BK_SWING: state_in = BK_SHADE;
         BK_SHADE: state_in = BK_EMIT;
         BK_EMIT:  if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      queue_pop = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         BK_IDLE: queue_pop = queue_valid;
         BK_EMIT: emit      = out_free;
         default: begin
            queue_pop = 1'b0;
            emit      = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // time modulo the two periods by reciprocal multiply
   assign hue_prod    = queue_word[31:4] * RECIP_125;
   assign breath_prod = queue_word[31:3] * RECIP_375;
   assign hue_tmp     = now_ff[31:4] - hue_q_ff * 28'd125;
   assign breath_tmp  = now_ff[31:3] - breath_q_ff * 29'd375;

   // hue sector and remainder
   assign hue3 = 13'(hue_ms_ff) * 13'd3;
   always_comb begin
      if (hue3 >= 13'd5000) begin
         sector_in = 3'd5;
      end else if (hue3 >= 13'd4000) begin
         sector_in = 3'd4;
      end else if (hue3 >= 13'd3000) begin
         sector_in = 3'd3;
      end else if (hue3 >= 13'd2000) begin
         sector_in = 3'd2;
      end else if (hue3 >= 13'd1000) begin
         sector_in = 3'd1;
      end else begin
         sector_in = 3'd0;
      end
   end
   assign rem_full = hue3 - 13'(sector_in) * 13'd1000;
   assign xprod_in = XW'(phase_ms_ff) * XW'(4 * SINE_TABLE_DEPTH);

   assign frac_prod = {rem_ff, 7'd0} * RECIP_FRAC;
   assign idx_prod  = IPW'(xprod_ff) * IPW'(RECIP_3000);

   // quadrant and table offset
   always_comb begin
      if (idx_ff >= IW'(3 * SINE_TABLE_DEPTH)) begin
         quad_in   = 2'd3;
         quad_base = IW'(3 * SINE_TABLE_DEPTH);
      end else if (idx_ff >= IW'(2 * SINE_TABLE_DEPTH)) begin
         quad_in   = 2'd2;
         quad_base = IW'(2 * SINE_TABLE_DEPTH);
      end else if (idx_ff >= IW'(SINE_TABLE_DEPTH)) begin
         quad_in   = 2'd1;
         quad_base = IW'(SINE_TABLE_DEPTH);
      end else begin
         quad_in   = 2'd0;
         quad_base = '0;
      end
   end
   assign offset_full = idx_ff - quad_base;
   assign offset      = offset_full[KW-1:0];
   // falling quadrants read the mirrored entry
   assign addr_in     = quad_in[0] ? (KW'(SINE_TABLE_DEPTH) - offset) : offset;

   assign mag   = unity_ff ? ONE_Q15 : rom_data;
   assign swing = 14'((swing_prod_ff + 29'd16384) >> 15);

   always_comb begin
      if (quad_ff[1]) begin
         br_in = (16'(swing) > BRIGHT_BASE_Q15) ? 16'd0 : BRIGHT_BASE_Q15 - 16'(swing);
      end else begin
         br_in = BRIGHT_BASE_Q15 + 16'(swing);
      end
      if (br_in > ONE_Q15) begin
         br_in = ONE_Q15;
      end
   end

   always_comb begin
      case (sector_ff)
         3'd0: begin
            r_sel = br_ff;  g_sel = bt_ff;  b_sel = 16'd0;
         end
         3'd1: begin
            r_sel = bq_ff;  g_sel = br_ff;  b_sel = 16'd0;
         end
         3'd2: begin
            r_sel = 16'd0;  g_sel = br_ff;  b_sel = bt_ff;
         end
         3'd3: begin
            r_sel = 16'd0;  g_sel = bq_ff;  b_sel = br_ff;
         end
         3'd4: begin
            r_sel = bt_ff;  g_sel = 16'd0;  b_sel = br_ff;
         end
         default: begin
            r_sel = br_ff;  g_sel = 16'd0;  b_sel = bq_ff;
         end
      endcase
   end

   assign r_prod = 24'(r_sel) * 24'(cfg.led_scale);
   assign g_prod = 24'(g_sel) * 24'(cfg.led_scale);
   assign b_prod = 24'(b_sel) * 24'(cfg.led_scale);

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            now_ff      <= queue_word;
            hue_q_ff    <= hue_prod[57:RECIP_125_SH];
            breath_q_ff <= breath_prod[59:RECIP_375_SH];
         end
         BK_REM: begin
            hue_ms_ff   <= {hue_tmp[6:0], now_ff[3:0]};
            phase_ms_ff <= {breath_tmp[8:0], now_ff[2:0]};
         end
         BK_SECT: begin
            sector_ff <= sector_in;
            rem_ff    <= rem_full[9:0];
            xprod_ff  <= xprod_in;
         end
         BK_MULT: begin
            fraction_ff <= frac_prod[RECIP_FRAC_SH +: 10];
            idx_ff      <= idx_prod[RECIP_3000_SH +: IW];
         end
         BK_ADDR: begin
            addr_ff  <= addr_in;
            quad_ff  <= quad_in;
            unity_ff <= quad_in[0] && (offset == '0);
         end
         BK_SINE: begin
            swing_prod_ff <= 29'(mag) * 29'(BRIGHT_SWING_Q15);
         end
         BK_SWING: begin
            br_ff <= br_in;
         end
         BK_SHADE: begin
            bt_ff <= 16'((27'(br_ff) * 27'(fraction_ff)) >> 10);
            bq_ff <= 16'((27'(br_ff) * 27'(11'd1024 - 11'(fraction_ff))) >> 10);
         end
         default: begin
         end
      endcase
      if (emit) begin
         red_ff   <= r_prod[22:15];
         green_ff <= g_prod[22:15];
         blue_ff  <= b_prod[22:15];
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.red   = red_ff;
   assign rsp.green = green_ff;
   assign rsp.blue  = blue_ff;

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SECT) |-> (hue_ms_ff < 11'(HUE_PERIOD_MS)))
      else $error("hue time out of period");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SECT) |-> (phase_ms_ff < 12'(BREATH_PERIOD_MS)))
      else $error("breathing phase out of period");

   a_bright_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SHADE) |-> (br_ff <= ONE_Q15))
      else $error("brightness above unity");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_valid_ff && (state_ff == BK_IDLE)))
      else $error("colour word not presented after emit");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import hrb_pkg::*;

   localparam int SINE_DEPTH     = SINE_TABLE_DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 16;

   // index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_word_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   hrb_req_if req_if ();
   hrb_rsp_if rsp_if ();

   hsv_rainbow_breathing_led u_top (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   // shadow of the block's registers and tick state
   logic        fx_enable   = CFG_RESET.effect_enable;
   logic [7:0]  fx_scale    = CFG_RESET.led_scale;
   logic [15:0] fx_interval = CFG_RESET.min_interval_ms;
   logic [31:0] last_tick   = '0;
   logic [15:0] sine_lut [SINE_DEPTH];

   rgb_word_type pending_colours [$];

   int errors          = 0;
   int ticks_sent      = 0;
   int colours_checked = 0;
   int settings_run    = 0;
   int rsp_hold        = 0;
   bit idling_on       = 1'b1;

   // quarter-wave table, q30 taylor series to x^13 then rounded to q1.15
   initial begin : sine_lut_build
      longint unsigned x, x2, mag, v, k, n;
      longint sum;
      for (k = 0; k < SINE_DEPTH; k++) begin
         x   = (HALF_PI_Q30 * k) / SINE_DEPTH;
         x2  = (x * x) >> 30;
         mag = x;
         sum = $signed(x);
         for (n = 1; n <= 6; n++) begin
            mag = ((mag * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - $signed(mag);
            else sum = sum + $signed(mag);
         end
         if (sum < 0) sum = 0;
         v = (longint'(sum) + (64'd1 << 14)) >> 15;
         if (v > ONE_Q15) v = ONE_Q15;
         sine_lut[k] = v[15:0];
      end
   end

   function automatic rgb_word_type breathing_colour(input logic [31:0] now);
      int unsigned hue, h3, sector, frac, phase, idx, quad, k, sine, swing;
      int unsigned br, bt, bq, r, g, b;
      rgb_word_type word;
      hue    = now % HUE_PERIOD_MS;
      h3     = hue * 3;
      sector = h3 / 1000;
      frac   = ((h3 % 1000) * 1024) / 1000;
      phase  = now % BREATH_PERIOD_MS;
      idx    = (phase * 4 * SINE_DEPTH) / BREATH_PERIOD_MS;
      quad   = (idx / SINE_DEPTH) & 3;
      k      = idx % SINE_DEPTH;
      // falling quadrants read the table backwards, peak at the seam
      if (quad & 1) sine = (k == 0) ? ONE_Q15 : sine_lut[SINE_DEPTH - k];
      else sine = sine_lut[k];
      swing = (BRIGHT_SWING_Q15 * sine + (1 << 14)) >> 15;
      if (quad & 2) br = (swing > BRIGHT_BASE_Q15) ? 0 : BRIGHT_BASE_Q15 - swing;
      else br = BRIGHT_BASE_Q15 + swing;
      if (br > ONE_Q15) br = ONE_Q15;
      bt = (br * frac) >> 10;
      bq = (br * (1024 - frac)) >> 10;
      case (sector)
         0: begin r = br; g = bt; b = 0; end
         1: begin r = bq; g = br; b = 0; end
         2: begin r = 0; g = br; b = bt; end
         3: begin r = 0; g = bq; b = br; end
         4: begin r = bt; g = 0; b = br; end
         default: begin r = br; g = 0; b = bq; end
      endcase
      word.red   = 8'((r * fx_scale) >> 15);
      word.green = 8'((g * fx_scale) >> 15);
      word.blue  = 8'((b * fx_scale) >> 15);
      return word;
   endfunction

   function automatic void take_tick(input logic [31:0] now);
      logic [31:0] elapsed;
      elapsed = now - last_tick;
      if (fx_enable && elapsed >= fx_interval) begin
         last_tick = now;
         pending_colours.push_back(breathing_colour(now));
      end
   endfunction

   function automatic int pick_gap();
      int unsigned pick;
      if (!idling_on) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      else if (pick < 92) return $urandom_range(1, 3);
      else return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] next_tick_time(input logic [31:0] cur,
                                                  input logic [15:0] interval);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return cur + interval + $urandom_range(0, 40);
      else if (pick < 85) return cur + $urandom_range(0, interval);
      else if (pick < 95) return cur + $urandom_range(0, 3000);
      else return $urandom;
   endfunction

   // valid is left high when no gap follows, so back-to-back words stay valid
   task automatic send_tick(input logic [31:0] now);
      int gap;
      req_if.valid  <= 1'b1;
      req_if.now_ms <= now;
      do @(posedge clock); while (!req_if.ready);
      take_tick(now);
      ticks_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid  <= 1'b0;
         req_if.now_ms <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         CSR_EFFECT_ENABLE:   fx_enable   = data[0];
         CSR_LED_SCALE:       fx_scale    = data[7:0];
         CSR_MIN_INTERVAL_MS: fx_interval = data[15:0];
         default: ;
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // dropped ticks give no word back, so allow for them after the queue empties
   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (pending_colours.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_state();
      // disabled out of reset
      send_tick(32'd100);
      send_tick(32'hFFFF_FFFF);
      send_tick(32'd0);
      settle_block();
      write_csr(CSR_EFFECT_ENABLE, 16'd1);
      // first interval counts from a last tick of zero
      send_tick(32'd29);
      send_tick(32'd30);
      send_tick(32'd59);
      send_tick(32'd60);
   endtask

   task automatic test_field_extremes();
      logic [31:0] probe [15] = '{32'd60, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'd333, 32'd334, 32'd667, 32'd1000,
                                  32'd1333, 32'd1666, 32'd1999, 32'd750, 32'd1500,
                                  32'd2250};
      settle_block();
      write_csr(CSR_MIN_INTERVAL_MS, 16'd0);
      // zero interval: every tick goes through, repeats included
      foreach (probe[i]) send_tick(probe[i]);
      settle_block();
      write_csr(CSR_MIN_INTERVAL_MS, 16'd30);
      // elapsed time across the 32-bit wrap
      send_tick(32'hFFFF_FFF0);
      send_tick(32'h0000_0008);
      send_tick(32'h0000_000E);
   endtask

   task automatic test_csr_corners();
      settle_block();
      write_csr(CSR_UNUSED, 16'h0000);
      send_tick(32'd5000);
      settle_block();
      // upper bits of the data word are dropped
      write_csr(CSR_LED_SCALE, 16'hAB00);
      write_csr(CSR_EFFECT_ENABLE, 16'hFFFE);
      send_tick(32'd6000);
      settle_block();
      write_csr(CSR_EFFECT_ENABLE, 16'h0003);
      send_tick(32'd7000);
   endtask

   task automatic test_output_backpressure();
      logic [31:0] t;
      settle_block();
      write_csr(CSR_EFFECT_ENABLE, 16'd1);
      write_csr(CSR_LED_SCALE, 16'd200);
      write_csr(CSR_MIN_INTERVAL_MS, 16'd0);
      idling_on = 1'b0;
      rsp_hold  = 300;
      t = $urandom;
      repeat (16) begin
         t = t + $urandom_range(0, 9);
         send_tick(t);
      end
   endtask

   task automatic run_phase(input logic en, input logic [7:0] scale,
                            input logic [15:0] interval, input int count,
                            input bit idle);
      logic [31:0] t;
      logic [15:0] junk;
      settle_block();
      junk = 16'($urandom);
      write_csr(CSR_EFFECT_ENABLE, {junk[15:1], en});
      write_csr(CSR_LED_SCALE, {junk[7:0], scale});
      write_csr(CSR_MIN_INTERVAL_MS, interval);
      settings_run++;
      idling_on = idle;
      t = $urandom;
      repeat (count) begin
         t = next_tick_time(t, interval);
         send_tick(t);
      end
   endtask

   task automatic test_random_settings();
      run_phase(1'b1, 8'd255, 16'd30, 150, 1'b1);
      run_phase(1'b1, 8'd0, 16'd0, 100, 1'b1);
      run_phase(1'b1, 8'd128, 16'd65535, 100, 1'b1);
      run_phase(1'b1, 8'd1, 16'd1, 150, 1'b0);
      run_phase(1'b0, 8'($urandom), 16'($urandom), 10, 1'b1);
      run_phase(1'b1, 8'($urandom_range(1, 254)), 16'($urandom_range(0, 200)), 250, 1'b1);
      run_phase(1'b1, 8'd255, 16'($urandom_range(0, 65535)), 100, 1'b1);
   endtask

   initial begin : rsp_ready_gen
      int stall;
      stall = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold--;
         end else if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   initial begin : colour_check
      rgb_word_type want;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_colours.size() == 0) begin
               $error("colour word %0d/%0d/%0d with no tick pending",
                      rsp_if.red, rsp_if.green, rsp_if.blue);
               errors++;
            end else begin
               want = pending_colours.pop_front();
               colours_checked++;
               if (rsp_if.red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, rsp_if.red);
                  errors++;
               end
               if (rsp_if.green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, rsp_if.green);
                  errors++;
               end
               if (rsp_if.blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, rsp_if.blue);
                  errors++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("FAIL hsv_rainbow_breathing_led");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.now_ms <= '0;
      csr_write_en  <= 1'b0;
      csr_index     <= CSR_EFFECT_ENABLE;
      csr_wdata     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_field_extremes();
      test_csr_corners();
      test_output_backpressure();
      test_random_settings();
      settle_block();
      $display("ticks sent: %0d, colour words checked: %0d, errors: %0d",
               ticks_sent, colours_checked, errors);
      $display("directed edges, csr corners, output hold-off and %0d random settings",
               settings_run);
      if (errors == 0) $display("PASS hsv_rainbow_breathing_led");
      else $display("FAIL hsv_rainbow_breathing_led");
      $finish;
   end

endmodule
